// File: sv/sorted_sleep_timer_queue_top_macros.svh
// ---------------------------------------------------------------------------
// Sorted sleep timer queue assertion macros
// Property shorthands clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_SLEEP_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_SLEEP_TIMER_QUEUE_TOP_MACROS_SVH

// Same-cycle implication.
`define SSTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSTQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sstq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted sleep timer queue package
// Shared widths, payload types, result kinds and wake time compare helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package sstq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NRES_W      = $clog2(MAX_RESULTS);

    localparam int TIME_W = 32;
    localparam int ID_W   = 16;
    localparam int SECS_W = 16;
    localparam int TPS_W  = 10;
    localparam int KIND_W = 3;
    localparam int PROD_W = TPS_W + SECS_W - 1;

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(10);

    typedef enum logic [KIND_W-1:0] {
        K_ACCEPTED = 3'd0,
        K_NEGATIVE = 3'd1,
        K_FULL     = 3'd2,
        K_WAKE     = 3'd3,
        K_IDLE     = 3'd4
    } t_kind;

    localparam logic ACT_SLEEP = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [ID_W-1:0]          sleeper_id;
        logic signed [SECS_W-1:0] seconds;
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   woken_id;
        logic              last;
    } t_res;

    typedef struct packed {
        logic              occ;
        logic [TIME_W-1:0] wake;
        logic [ID_W-1:0]   id;
    } t_entry;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [TIME_W-1:0] wake;
        logic [ID_W-1:0]   id;
    } t_cell_ctrl;

    // True when a lies strictly before b in wrap-safe order.
    function automatic logic earlier(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

    function automatic logic is_due(input logic [TIME_W-1:0] wake,
                                    input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] d;
        d = wake - now;
        return (d == '0) || d[TIME_W-1];
    endfunction

endpackage

`default_nettype wire

// File: sv/sstq_req_if.sv
// ---------------------------------------------------------------------------
// Sleep and tick request channel
// Valid/ready channel that carries one request item.
// ---------------------------------------------------------------------------
`default_nettype none

interface sstq_req_if;
    import sstq_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/sstq_res_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result item.
// ---------------------------------------------------------------------------
`default_nettype none

interface sstq_res_if;
    import sstq_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/sstq_cfg_if.sv
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries the ticks-per-second register value.
// ---------------------------------------------------------------------------
`default_nettype none

interface sstq_cfg_if;
    import sstq_pkg::*;

    logic             valid;
    logic             ready;
    logic [TPS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/sstq_cell.sv
// ---------------------------------------------------------------------------
// Sorted queue cell
// Holds one queue entry; shifts right on insert, left on pop.
// ---------------------------------------------------------------------------
`default_nettype none

module sstq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sstq_pkg::t_cell_ctrl i_ctrl,
    input  sstq_pkg::t_entry    i_left,
    input  sstq_pkg::t_entry    i_right,
    input  logic                i_found,
    output logic                o_found,
    output sstq_pkg::t_entry    o_ent
);
    import sstq_pkg::*;

    logic              r_occ;
    logic [TIME_W-1:0] r_wake;
    logic [ID_W-1:0]   r_id;
    t_entry            n_ent;
    logic              w_stop;

    // The insert position is the first cell that is empty or not earlier
    // than the new wake time; the found flag ripples along the row from it.
    always_comb begin
        w_stop  = !r_occ || !earlier(r_wake, i_ctrl.wake);
        o_found = i_found | w_stop;
        n_ent   = '{occ: r_occ, wake: r_wake, id: r_id};
        if (i_ctrl.pop) begin
            n_ent = i_right;
        end else if (i_ctrl.ins) begin
            if (i_found) begin
                n_ent = i_left;
            end else if (w_stop) begin
                n_ent = '{occ: 1'b1, wake: i_ctrl.wake, id: i_ctrl.id};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_ent.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wake <= n_ent.wake;
        r_id   <= n_ent.id;
    end

    assign o_ent = '{occ: r_occ, wake: r_wake, id: r_id};

endmodule

`default_nettype wire

// File: sv/sstq_chain.sv
// ---------------------------------------------------------------------------
// Sorted queue cell row
// Links the cells into a row; cell 0 is the head of the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module sstq_chain (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sstq_pkg::t_cell_ctrl i_ctrl,
    output sstq_pkg::t_entry     o_ents [sstq_pkg::QUEUE_DEPTH]
);
    import sstq_pkg::*;

    logic   w_found [QUEUE_DEPTH+1];
    t_entry w_left  [QUEUE_DEPTH];
    t_entry w_right [QUEUE_DEPTH];

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '0;
        end else begin : g_mid
            assign w_left[g] = o_ents[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right[g] = '0;
        end else begin : g_body
            assign w_right[g] = o_ents[g+1];
        end

        sstq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (i_ctrl),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_found (w_found[g]),
            .o_found (w_found[g+1]),
            .o_ent   (o_ents[g])
        );
    end

endmodule

`default_nettype wire

// File: sv/sorted_sleep_timer_queue_top.sv
// ---------------------------------------------------------------------------
// Sorted sleep timer queue
// Tick counter plus a wake-time ordered row of sleeper cells.
// ---------------------------------------------------------------------------
//  Channel   Dir  Carries
//  i_req     in   action, sleeper_id, seconds
//  o_res     out  kind, woken_id, last
//  i_cfg     in   ticks_per_second
//
// A sleep request passes three steps: product, wake time sum, insert. A tick
// wakes due sleepers from the head one by one; the head cell is popped once
// per cycle while the result register can take a result. One item is in work
// at a time. The result register holds a stalled result while the next step
// waits for it. Reset empties the queue at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sorted_sleep_timer_queue_top_macros.svh"

module sorted_sleep_timer_queue_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sstq_req_if.sink     i_req,
    sstq_res_if.source   o_res,
    sstq_cfg_if.sink     i_cfg
);
    import sstq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_INS  = 4'b0100,
        S_TICK = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_tick;
    logic [TPS_W-1:0]  r_tps;
    logic [PROD_W-1:0] r_prod;
    logic [TIME_W-1:0] r_wake;
    logic [ID_W-1:0]   r_id;
    logic              r_neg;
    logic [NRES_W-1:0] r_nres;
    logic              r_out_valid;
    t_res              r_out;

    t_cell_ctrl        w_ctrl;
    t_entry            w_ents [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_occ;
    logic              w_load;
    logic              w_emit;
    t_res              w_res;
    logic              w_due0;
    logic              w_due1;
    logic              w_accept;
    logic [PROD_W-1:0] w_prod;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_occ
        assign w_occ[g] = w_ents[g].occ;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign w_accept = i_req.valid && (r_state == S_IDLE);
    assign w_load   = !r_out_valid || o_res.ready;
    assign w_prod   = PROD_W'(r_tps) * PROD_W'(i_req.data.seconds[SECS_W-2:0]);
    assign w_due0   = w_ents[0].occ && is_due(w_ents[0].wake, r_tick);
    assign w_due1   = w_ents[1].occ && is_due(w_ents[1].wake, r_tick);

    always_comb begin
        n_state = r_state;
        w_emit  = 1'b0;
        w_res   = '{kind: K_IDLE, woken_id: '0, last: 1'b1};
        w_ctrl  = '{ins: 1'b0, pop: 1'b0, wake: r_wake, id: r_id};
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.data.action == ACT_TICK) ? S_TICK : S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_INS;
            end
            S_INS: begin
                if (w_load) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (r_neg) begin
                        w_res.kind = K_NEGATIVE;
                    end else if (w_occ[QUEUE_DEPTH-1]) begin
                        w_res.kind = K_FULL;
                    end else begin
                        w_res.kind = K_ACCEPTED;
                        w_ctrl.ins = 1'b1;
                    end
                end
            end
            S_TICK: begin
                if (w_load) begin
                    w_emit = 1'b1;
                    if (w_due0) begin
                        w_res.kind     = K_WAKE;
                        w_res.woken_id = w_ents[0].id;
                        w_res.last     = (r_nres == NRES_W'(MAX_RESULTS - 1)) || !w_due1;
                        w_ctrl.pop     = 1'b1;
                        if (w_res.last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    sstq_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_ents  (w_ents)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_tps       <= TPS_RESET;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_tps <= i_cfg.data;
            end
            if (w_accept && (i_req.data.action == ACT_TICK)) begin
                r_tick <= r_tick + TIME_W'(1);
                r_nres <= '0;
            end else if (w_ctrl.pop) begin
                r_nres <= r_nres + NRES_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod <= w_prod;
            r_id   <= i_req.data.sleeper_id;
            r_neg  <= i_req.data.seconds[SECS_W-1];
        end
        if (r_state == S_SUM) begin
            r_wake <= r_tick + TIME_W'(r_prod);
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    // Occupied cells always form an unbroken run from the head.
    `SSTQ_ASSERT_IMP(a_occ_contig, 1'b1, ((w_occ >> 1) & ~w_occ) == '0, "queue has a hole")
    `SSTQ_ASSERT_IMP(a_no_ins_full, w_ctrl.ins, !w_occ[QUEUE_DEPTH-1], "insert into full queue")
    `SSTQ_ASSERT_NXT(a_ins_grows, w_ctrl.ins,
        $countones(w_occ) == $past($countones(w_occ)) + 1, "insert lost an entry")
    `SSTQ_ASSERT_NXT(a_pop_shrinks, w_ctrl.pop,
        $countones(w_occ) + 1 == $past($countones(w_occ)), "pop miscounted")
    `SSTQ_ASSERT_NXT(a_last_ends, w_emit && w_res.last, r_state == S_IDLE,
        "work continued after last result")

endmodule

`default_nettype wire
